// File: rtl/core/egg_pkg.sv
// egg drop solver package: widths, table geometry and sequencer states
// no dependencies
package egg_pkg;

  localparam int unsigned EGG_W      = 4;
  localparam int unsigned FLOOR_W    = 8;
  localparam int unsigned ATT_W      = 8;
  localparam int unsigned MAX_EGGS   = 15;
  localparam int unsigned MAX_FLOORS = 255;
  localparam int unsigned ADDR_W     = EGG_W + FLOOR_W;
  localparam int unsigned TBL_DEPTH  = 1 << ADDR_W;
  localparam int unsigned S_DATA_W   = ((EGG_W + FLOOR_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W   = ((ATT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } egg_state_e;

endpackage

// File: rtl/core/egg_drop_min_attempts_top.sv
// egg drop solver top: sequencer filling the attempt table, one compare per cycle
// depends on egg_pkg and egg_ram
//
// channel  dir  tdata (low bit up)                      tuser/tlast
// s_axis   in   egg_count[3:0], floor_count[11:4]       none
// m_axis   out  min_attempts[7:0]                       none
//
// for e eggs and f floors (e saturated to 1..15) the table is filled row by row;
// cells with k >= 2 floors and at least two eggs go through cell, scan over k
// drop floors and drain, others only cell; the single compare loop reads the
// two-read table ram; s_axis_tready stays low while solving.
// the result sits in an output register; a new word is taken while it waits.
// asynchronous active-low reset clears control state; the table needs no clear.
module egg_drop_min_attempts_top
  import egg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,   // egg_count, floor_count, zero pad
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o    // min_attempts
);

  egg_state_e state_q, state_d;

  logic [EGG_W-1:0]   eggs_q, eggs_d, e_q, e_d;
  logic [FLOOR_W-1:0] floors_q, floors_d, f_q, f_d, x_q, x_d;
  logic [ATT_W:0]     best_q, best_d;
  logic [ATT_W-1:0]   res_q, res_d, out_q, out_d;
  logic               rd_vld_q, rd_vld_d, out_vld_q, out_vld_d;

  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  logic [ATT_W-1:0]   wdata, rdata_a, rdata_b;
  logic [ATT_W:0]     worst, best_upd;
  logic [EGG_W-1:0]   in_eggs;
  logic [FLOOR_W-1:0] in_floors;
  logic               in_acc, last_cell, trivial;

  egg_ram #(
    .WIDTH(ATT_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_eggs   = s_axis_tdata_i[EGG_W-1:0];
  assign in_floors = s_axis_tdata_i[EGG_W+FLOOR_W-1:EGG_W];

  assign worst     = {1'b0, (rdata_a > rdata_b) ? rdata_a : rdata_b} + {{ATT_W{1'b0}}, 1'b1};
  assign best_upd  = (rd_vld_q && (worst < best_q)) ? worst : best_q;
  assign last_cell = (f_q == floors_q) && (e_q == eggs_q);
  assign trivial   = (f_q <= FLOOR_W'(1)) || (e_q == EGG_W'(1));

  assign raddr_a   = {e_q - EGG_W'(1), x_q - FLOOR_W'(1)};
  assign raddr_b   = {e_q, f_q - x_q};
  assign waddr     = {e_q, f_q};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = M_DATA_W'(out_q);

  always_comb begin
    state_d   = state_q;
    eggs_d    = eggs_q;
    floors_d  = floors_q;
    e_d       = e_q;
    f_d       = f_q;
    x_d       = x_q;
    best_d    = best_upd;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    rd_vld_d  = 1'b0;
    we        = 1'b0;
    wdata     = f_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_eggs == EGG_W'(0)) begin
            eggs_d = EGG_W'(1);
          end else if (32'(in_eggs) > MAX_EGGS) begin
            eggs_d = EGG_W'(MAX_EGGS);
          end else begin
            eggs_d = in_eggs;
          end
          floors_d = (32'(in_floors) > MAX_FLOORS) ? FLOOR_W'(MAX_FLOORS) : in_floors;
          e_d      = EGG_W'(1);
          f_d      = '0;
          state_d  = S_CELL;
        end
      end
      S_CELL: begin
        if (trivial) begin
          we    = 1'b1;
          wdata = f_q;
        end else begin
          best_d  = '1;
          x_d     = FLOOR_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_vld_d = 1'b1;
        x_d      = x_q + FLOOR_W'(1);
        if (x_q == f_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        we    = 1'b1;
        wdata = best_upd[ATT_W-1:0];
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (we) begin
      if (last_cell) begin
        res_d   = wdata;
        state_d = S_DONE;
      end else begin
        state_d = S_CELL;
        if (f_q == floors_q) begin
          e_d = e_q + EGG_W'(1);
          f_d = '0;
        end else begin
          f_d = f_q + FLOOR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eggs_q   <= eggs_d;
    floors_q <= floors_d;
    e_q      <= e_d;
    f_q      <= f_d;
    x_q      <= x_d;
    best_q   <= best_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (x_q != FLOOR_W'(0)) && (x_q <= f_q))
    else $error("scan index out of range");

  a_rd_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == S_SCAN)
    else $error("read data flagged without a scan issue");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_CELL && e_q == EGG_W'(1) && f_q == FLOOR_W'(0))
    else $error("accepted word did not start at the first cell");

  a_one_egg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we && e_q == EGG_W'(1) |-> wdata == f_q)
    else $error("one egg cell not equal to floor count");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> res_q <= floors_q)
    else $error("result exceeds floor count");
`endif

endmodule

// File: rtl/core/egg_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
module egg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: bench/egg_drop_checker.sv
// egg drop solver checker: watches both stream channels, predicts each answer
// by filling its own drop table, and compares every result word in order
// depends on egg_pkg
module egg_drop_checker
  import egg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [S_DATA_W-1:0] s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [M_DATA_W-1:0] m_tdata_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         words_checked_o,
  output int unsigned         words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [EGG_W-1:0]   eggs;
    logic [FLOOR_W-1:0] floors;
    logic [ATT_W-1:0]   drops;
  } drop_answer_t;

  logic [ATT_W-1:0] drop_tbl [MAX_EGGS+1][MAX_FLOORS+1];
  drop_answer_t     answers_due [$];

  function automatic logic [ATT_W-1:0] solve_drops(input int unsigned eggs_in,
                                                   input int unsigned floors_in);
    int unsigned eggs;
    int unsigned floors;
    int unsigned best;
    int unsigned worst;
    int unsigned breaks;
    int unsigned holds;
    eggs   = (eggs_in == 0) ? 1 : eggs_in;
    eggs   = (eggs > MAX_EGGS) ? MAX_EGGS : eggs;
    floors = (floors_in > MAX_FLOORS) ? MAX_FLOORS : floors_in;
    for (int unsigned e = 1; e <= eggs; e++) begin
      for (int unsigned f = 0; f <= floors; f++) begin
        if (f <= 1 || e == 1) begin
          best = f;
        end else begin
          best = 32'hFFFF_FFFF;
          // first drop at floor x: egg breaks below, or holds above
          for (int unsigned x = 1; x <= f; x++) begin
            breaks = 32'(drop_tbl[e-1][x-1]);
            holds  = 32'(drop_tbl[e][f-x]);
            worst  = 1 + ((breaks > holds) ? breaks : holds);
            if (worst < best) best = worst;
          end
        end
        drop_tbl[e][f] = best[ATT_W-1:0];
      end
    end
    return drop_tbl[eggs][floors];
  endfunction

  always @(posedge clk_i) begin
    drop_answer_t due;
    drop_answer_t req;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (answers_due.size() == 0) begin
          $error("min_attempts expected none actual %0d", m_tdata_i[ATT_W-1:0]);
          mismatch_count_o++;
        end else begin
          due = answers_due.pop_front();
          words_checked_o++;
          if (m_tdata_i[ATT_W-1:0] !== due.drops) begin
            $error("min_attempts expected %0d actual %0d (eggs %0d floors %0d)",
                   due.drops, m_tdata_i[ATT_W-1:0], due.eggs, due.floors);
            mismatch_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        req.eggs   = s_tdata_i[EGG_W-1:0];
        req.floors = s_tdata_i[EGG_W +: FLOOR_W];
        req.drops  = solve_drops(32'(req.eggs), 32'(req.floors));
        answers_due.push_back(req);
      end
      words_pending_o = answers_due.size();
    end
  end

endmodule

// File: bench/tb_top.sv
// egg drop solver testbench top: clock, reset, request and result streams
// with random gaps, and the verdict; depends on egg_pkg, egg_drop_checker
// and egg_drop_min_attempts_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import egg_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;   // egg_count, floor_count, zero pad
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;   // min_attempts

  int unsigned mismatch_count;
  int unsigned words_checked;
  int unsigned words_pending;
  int unsigned words_sent;
  bit          steady_feed;

  egg_drop_min_attempts_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  egg_drop_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .words_checked_o  (words_checked),
    .words_pending_o  (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_request(input logic [EGG_W-1:0] eggs,
                              input logic [FLOOR_W-1:0] floors);
    int unsigned gap;
    logic        took;
    if ($urandom_range(0, 11) == 0) steady_feed = !steady_feed;
    gap = steady_feed ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'({floors, eggs});
    // ready is stable between the falling and the next rising edge
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    words_sent++;
  endtask

  task automatic drain_results();
    int unsigned gap;
    logic        took;
    bit          steady;
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        // stall while a result word is waiting
        m_axis_tready <= 1'b0;
        do @(negedge clk_i); while (!m_axis_tvalid);
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = m_axis_tvalid;
        @(posedge clk_i);
      end while (!took);
    end
  endtask

  initial begin
    int unsigned      pick;
    logic [EGG_W-1:0]   eggs;
    logic [FLOOR_W-1:0] floors;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_results();
    join_none

    // extremes, zero eggs, trivial floor counts and alternating bit patterns
    send_request(4'd15, 8'd255);
    send_request(4'd0,  8'd0);
    send_request(4'd0,  8'd255);
    send_request(4'd0,  8'd7);
    send_request(4'd1,  8'd0);
    send_request(4'd1,  8'd1);
    send_request(4'd1,  8'd255);
    send_request(4'd15, 8'd0);
    send_request(4'd15, 8'd1);
    send_request(4'd15, 8'd2);
    send_request(4'd2,  8'd2);
    send_request(4'd2,  8'd255);
    send_request(4'd2,  8'd170);
    send_request(4'd4,  8'd85);
    send_request(4'd10, 8'd36);
    send_request(4'd5,  8'd15);
    send_request(4'd3,  8'd128);
    send_request(4'd6,  8'd63);
    send_request(4'd7,  8'd100);
    send_request(4'd14, 8'd3);

    // mostly small buildings, a few tall ones with few eggs
    for (int i = 0; i < 80; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        eggs   = 4'd2;
        floors = FLOOR_W'($urandom_range(0, 255));
      end else if (pick < 3) begin
        eggs   = EGG_W'($urandom_range(0, 1));
        floors = FLOOR_W'($urandom);
      end else begin
        eggs   = EGG_W'($urandom);
        floors = FLOOR_W'($urandom_range(0, 40));
      end
      send_request(eggs, floors);
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (words_pending != 0);
    repeat (40) @(posedge clk_i);

    $display("sent %0d requests and checked %0d answers", words_sent, words_checked);
    $display("eggs 0 to 15 and floors 0 to 255, the full table once");
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
